// ----- rtl/clkled_pkg.sv -----
// shared types, constants and helpers for the clock-time LED panel command block
package clkled_pkg;

    // field widths
    localparam int TS_W    = 32;
    localparam int BYTE_W  = 8;
    localparam int QD_W    = 16;
    localparam int DAY_W   = 17;
    localparam int HOUR_W  = 5;
    localparam int REM_W   = 12;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DIGIT_W = 4;

    // time constants
    localparam int unsigned SECS_DAY      = 86400;
    localparam int unsigned SECS_HOUR     = 3600;
    localparam int unsigned SECS_MIN      = 60;
    localparam int unsigned MINS_PER_HOUR = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned ROUND_LIMIT   = 30;

    // reciprocals for divide by constant (underestimate by at most one)
    localparam int DAY_SHIFT  = 48;
    localparam int HOUR_SHIFT = 32;
    localparam int MIN_SHIFT  = 24;
    localparam logic [31:0] RECIP_DAY  = 32'((64'd1 << DAY_SHIFT) / 64'd86400);
    localparam logic [20:0] RECIP_HOUR = 21'((64'd1 << HOUR_SHIFT) / 64'd3600);
    localparam logic [18:0] RECIP_MIN  = 19'((64'd1 << MIN_SHIFT) / 64'd60);

    // panel command bytes
    localparam logic [BYTE_W-1:0] CMD_WRITE      = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_COLON      = 8'h24;
    localparam logic [BYTE_W-1:0] COLON_ON       = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_BRIGHT     = 8'h30;
    localparam logic [BYTE_W-1:0] BRIGHT_LOW     = 8'h05 | 8'h18;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON = 8'h2D;

    // seven-segment patterns for digits 0..9
    localparam logic [BYTE_W-1:0] SEG_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // position of a beat within the ten-beat command stream
    typedef enum logic [3:0] {
        POS_WRITE_CMD,
        POS_HOUR_TENS,
        POS_HOUR_UNITS,
        POS_MIN_TENS,
        POS_MIN_UNITS,
        POS_COLON_CMD,
        POS_COLON_DATA,
        POS_BRIGHT_CMD,
        POS_BRIGHT_DATA,
        POS_DISPLAY_ON
    } t_beat_pos;

    // queue entry: the four digit patterns
    typedef struct packed {
        logic [BYTE_W-1:0] hour_tens;
        logic [BYTE_W-1:0] hour_units;
        logic [BYTE_W-1:0] min_tens;
        logic [BYTE_W-1:0] min_units;
    } t_digit_segs;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } t_dec;

    // split a value below 60 into decimal digits
    function automatic t_dec split_dec(input logic [MIN_W-1:0] v);
        t_dec d;
        priority if (v >= MIN_W'(50)) begin
            d.tens  = DIGIT_W'(5);
            d.units = DIGIT_W'(v - MIN_W'(50));
        end else if (v >= MIN_W'(40)) begin
            d.tens  = DIGIT_W'(4);
            d.units = DIGIT_W'(v - MIN_W'(40));
        end else if (v >= MIN_W'(30)) begin
            d.tens  = DIGIT_W'(3);
            d.units = DIGIT_W'(v - MIN_W'(30));
        end else if (v >= MIN_W'(20)) begin
            d.tens  = DIGIT_W'(2);
            d.units = DIGIT_W'(v - MIN_W'(20));
        end else if (v >= MIN_W'(10)) begin
            d.tens  = DIGIT_W'(1);
            d.units = DIGIT_W'(v - MIN_W'(10));
        end else begin
            d.tens  = '0;
            d.units = DIGIT_W'(v);
        end
        return d;
    endfunction

    // seven-segment lookup
    function automatic logic [BYTE_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        return (d <= DIGIT_W'(9)) ? SEG_TABLE[d] : '0;
    endfunction

endpackage

// ----- rtl/clkled_ts_if.sv -----
// timestamp input channel
interface clkled_ts_if import clkled_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [TS_W-1:0] timestamp_seconds;

    modport source (output valid, output timestamp_seconds, input ready);
    modport sink   (input valid, input timestamp_seconds, output ready);
endinterface

// ----- rtl/clkled_cmd_if.sv -----
// panel command byte output channel
interface clkled_cmd_if import clkled_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_start;
    logic              frame_end;
    logic              last;

    modport source (output valid, output out_byte, output frame_start, output frame_end,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input frame_start, input frame_end,
                    input last, output ready);
endinterface

// ----- rtl/clock_time_to_led_panel_commands.sv -----
// top level: seconds timestamp to LED panel command beats
//
// Input channel i_ts carries one 32-bit seconds timestamp per beat. Output
// channel o_cmd carries ten beats per timestamp: out_byte plus frame_start,
// frame_end and last, meant for a bit serializer that drives the panel.
// The front is a nine-stage pipeline (reciprocal multiplies with one
// correction step each) that turns the timestamp into hour/minute digit
// patterns; a small queue decouples it from the back, which emits one beat
// per cycle from an output register while o_cmd.ready is high.
// The back, emitting ten beats per timestamp, sets the throughput; the front
// takes a new timestamp every cycle until the queue and pipeline fill.
// Reset (i_rst_n low, synchronous) empties pipeline, queue and output.
// When the receiver holds o_cmd.ready low, the current beat holds, the back
// stops, the queue fills and then i_ts.ready drops; nothing is lost.
module clock_time_to_led_panel_commands import clkled_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    clkled_ts_if.sink    i_ts,
    clkled_cmd_if.source o_cmd
);

    logic        w_push, w_full, w_q_valid, w_pop;
    t_digit_segs w_push_data, w_q_data;

    // classify timestamps into digit patterns
    clkled_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ts        (i_ts),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // decoupling queue
    clkled_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_pop)
    );

    // emit command beats
    clkled_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_cmd     (o_cmd)
    );

endmodule

// ----- rtl/clkled_front.sv -----
// front pipeline: timestamp to rounded hour/minute and digit patterns
module clkled_front import clkled_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clkled_ts_if.sink   i_ts,
    input  logic        i_q_full,
    output logic        o_push,
    output t_digit_segs o_push_data
);

    localparam int NSTG = 9;

    logic [NSTG-1:0] r_vld, n_vld;
    logic            w_en, w_acc;

    // stage registers
    logic [TS_W-1:0]   r_a_ts;
    logic [TS_W-1:0]   r_b_ts;
    logic [QD_W-1:0]   r_b_qd, n_b_qd;
    logic [DAY_W-1:0]  r_c_day, n_c_day;
    logic [DAY_W-1:0]  r_d_day;
    logic [HOUR_W-1:0] r_d_qh, n_d_qh;
    logic [HOUR_W-1:0] r_e_hour, n_e_hour;
    logic [REM_W-1:0]  r_e_rem, n_e_rem;
    logic [HOUR_W-1:0] r_f_hour;
    logic [REM_W-1:0]  r_f_rem;
    logic [MIN_W-1:0]  r_f_qm, n_f_qm;
    logic [HOUR_W-1:0] r_g_hour;
    logic [MIN_W-1:0]  r_g_min, n_g_min;
    logic [SEC_W-1:0]  r_g_sec, n_g_sec;
    logic [HOUR_W-1:0] r_h_hour, n_h_hour;
    logic [MIN_W-1:0]  r_h_min, n_h_min;
    t_digit_segs       r_i_segs, n_i_segs;

    // intermediate products and differences
    logic [63:0]       w_b_prod;
    logic [32:0]       w_c_prod;
    logic [17:0]       w_c_diff;
    logic [37:0]       w_d_prod;
    logic [DAY_W-1:0]  w_e_prod, w_e_diff;
    logic [30:0]       w_f_prod;
    logic [REM_W-1:0]  w_g_prod, w_g_diff;
    logic              w_round;
    logic [MIN_W-1:0]  w_min1;
    logic [HOUR_W-1:0] w_hour1;
    t_dec              w_hd, w_md;

    // whole pipeline advances unless the last stage is blocked by a full queue
    assign w_en        = !(r_vld[NSTG-1] && i_q_full);
    assign i_ts.ready  = w_en;
    assign w_acc       = i_ts.valid && w_en;
    assign o_push      = r_vld[NSTG-1] && !i_q_full;
    assign o_push_data = r_i_segs;
    assign n_vld       = {r_vld[NSTG-2:0], w_acc};

    // stage b: day quotient estimate
    assign w_b_prod = 64'(r_a_ts) * 64'(RECIP_DAY);
    assign n_b_qd   = w_b_prod[DAY_SHIFT +: QD_W];

    // stage c: seconds of day with one correction step
    assign w_c_prod = 33'(r_b_qd) * 33'(SECS_DAY);
    assign w_c_diff = 18'(33'(r_b_ts) - w_c_prod);
    assign n_c_day  = (w_c_diff >= 18'(SECS_DAY)) ? DAY_W'(w_c_diff - 18'(SECS_DAY))
                                                   : DAY_W'(w_c_diff);

    // stage d: hour estimate
    assign w_d_prod = 38'(r_c_day) * 38'(RECIP_HOUR);
    assign n_d_qh   = w_d_prod[HOUR_SHIFT +: HOUR_W];

    // stage e: hour and seconds within the hour
    assign w_e_prod = DAY_W'(r_d_qh) * DAY_W'(SECS_HOUR);
    assign w_e_diff = r_d_day - w_e_prod;
    always_comb begin
        if (w_e_diff >= DAY_W'(SECS_HOUR)) begin
            n_e_hour = r_d_qh + HOUR_W'(1);
            n_e_rem  = REM_W'(w_e_diff - DAY_W'(SECS_HOUR));
        end else begin
            n_e_hour = r_d_qh;
            n_e_rem  = REM_W'(w_e_diff);
        end
    end

    // stage f: minute estimate
    assign w_f_prod = 31'(r_e_rem) * 31'(RECIP_MIN);
    assign n_f_qm   = w_f_prod[MIN_SHIFT +: MIN_W];

    // stage g: minute and second
    assign w_g_prod = REM_W'(r_f_qm) * REM_W'(SECS_MIN);
    assign w_g_diff = r_f_rem - w_g_prod;
    always_comb begin
        if (w_g_diff >= REM_W'(SECS_MIN)) begin
            n_g_min = r_f_qm + MIN_W'(1);
            n_g_sec = SEC_W'(w_g_diff - REM_W'(SECS_MIN));
        end else begin
            n_g_min = r_f_qm;
            n_g_sec = SEC_W'(w_g_diff);
        end
    end

    // stage h: round the minute, carry into the hour, wrap at midnight
    assign w_round = r_g_sec > SEC_W'(ROUND_LIMIT);
    assign w_min1  = r_g_min + MIN_W'(w_round);
    always_comb begin
        if (w_min1 == MIN_W'(MINS_PER_HOUR)) begin
            n_h_min = '0;
            w_hour1 = r_g_hour + HOUR_W'(1);
        end else begin
            n_h_min = w_min1;
            w_hour1 = r_g_hour;
        end
        n_h_hour = (w_hour1 == HOUR_W'(HOURS_PER_DAY)) ? '0 : w_hour1;
    end

    // stage i: decimal digits and segment patterns
    assign w_hd = split_dec(MIN_W'(r_h_hour));
    assign w_md = split_dec(r_h_min);
    always_comb begin
        n_i_segs.hour_tens  = seg_of(w_hd.tens);
        n_i_segs.hour_units = seg_of(w_hd.units);
        n_i_segs.min_tens   = seg_of(w_md.tens);
        n_i_segs.min_units  = seg_of(w_md.units);
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ts   <= i_ts.timestamp_seconds;
            r_b_ts   <= r_a_ts;
            r_b_qd   <= n_b_qd;
            r_c_day  <= n_c_day;
            r_d_day  <= r_c_day;
            r_d_qh   <= n_d_qh;
            r_e_hour <= n_e_hour;
            r_e_rem  <= n_e_rem;
            r_f_hour <= r_e_hour;
            r_f_rem  <= r_e_rem;
            r_f_qm   <= n_f_qm;
            r_g_hour <= r_f_hour;
            r_g_min  <= n_g_min;
            r_g_sec  <= n_g_sec;
            r_h_hour <= n_h_hour;
            r_h_min  <= n_h_min;
            r_i_segs <= n_i_segs;
        end
    end

endmodule

// ----- rtl/clkled_queue.sv -----
// small queue of digit patterns between front and back
module clkled_queue import clkled_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_digit_segs i_push_data,
    output logic        o_full,
    output logic        o_valid,
    output t_digit_segs o_data,
    input  logic        i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_digit_segs   r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("queue count did not follow push");
`endif

endmodule

// ----- rtl/clkled_back.sv -----
// back end: expands one set of digit patterns into ten framed command beats
module clkled_back import clkled_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_digit_segs  i_q_data,
    output logic         o_q_pop,
    clkled_cmd_if.source o_cmd
);

    t_digit_segs       r_segs;
    logic              r_have;
    t_beat_pos         r_idx;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_fs, n_fs;
    logic              r_fe, n_fe;
    logic              r_last, n_last;
    logic              w_load, w_end;

    // load the output register when it is empty or being drained
    assign w_load  = r_have && (!r_ov || o_cmd.ready);
    assign w_end   = w_load && (r_idx == POS_DISPLAY_ON);
    assign o_q_pop = i_q_valid && (!r_have || w_end);

    assign o_cmd.valid       = r_ov;
    assign o_cmd.out_byte    = r_byte;
    assign o_cmd.frame_start = r_fs;
    assign o_cmd.frame_end   = r_fe;
    assign o_cmd.last        = r_last;

    // beat contents by position
    always_comb begin
        n_byte = '0;
        n_fs   = 1'b0;
        n_fe   = 1'b0;
        n_last = 1'b0;
        unique case (r_idx)
            POS_WRITE_CMD: begin
                n_byte = CMD_WRITE;
                n_fs   = 1'b1;
            end
            POS_HOUR_TENS:  n_byte = r_segs.hour_tens;
            POS_HOUR_UNITS: n_byte = r_segs.hour_units;
            POS_MIN_TENS:   n_byte = r_segs.min_tens;
            POS_MIN_UNITS: begin
                n_byte = r_segs.min_units;
                n_fe   = 1'b1;
            end
            POS_COLON_CMD: begin
                n_byte = CMD_COLON;
                n_fs   = 1'b1;
            end
            POS_COLON_DATA: begin
                n_byte = COLON_ON;
                n_fe   = 1'b1;
            end
            POS_BRIGHT_CMD: begin
                n_byte = CMD_BRIGHT;
                n_fs   = 1'b1;
            end
            POS_BRIGHT_DATA: begin
                n_byte = BRIGHT_LOW;
                n_fe   = 1'b1;
            end
            POS_DISPLAY_ON: begin
                n_byte = CMD_DISPLAY_ON;
                n_fs   = 1'b1;
                n_fe   = 1'b1;
                n_last = 1'b1;
            end
            default: begin
                n_byte = '0;
            end
        endcase
    end

    // sequencing and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= POS_WRITE_CMD;
            r_ov   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_have <= 1'b1;
                r_idx  <= POS_WRITE_CMD;
            end else if (w_end) begin
                r_have <= 1'b0;
            end else if (w_load) begin
                r_idx  <= t_beat_pos'(r_idx + 4'd1);
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_cmd.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_segs <= i_q_data;
        end
        if (w_load) begin
            r_byte <= n_byte;
            r_fs   <= n_fs;
            r_fe   <= n_fe;
            r_last <= n_last;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_idx <= POS_DISPLAY_ON))
        else $error("beat position out of range");

    a_end_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (o_cmd.valid && o_cmd.last))
        else $error("final beat not marked last");

    a_last_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.last) |-> (o_cmd.frame_start && o_cmd.frame_end))
        else $error("last beat not a single-byte frame");
`endif

endmodule

// ----- tb/clock_time_to_led_panel_commands_test.sv -----
// testbench for the clock-time to LED panel command stream block
`timescale 1ns / 100ps

module clock_time_to_led_panel_commands_test;
    import clkled_pkg::*;

    // run control
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned RANDOM_ITEMS  = 240;
    localparam int unsigned HOLD_AT_BEAT  = 300;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned MAX_REPORTS   = 10;

    // panel command bytes
    localparam logic [7:0] PANEL_WRITE      = 8'h00;
    localparam logic [7:0] PANEL_COLON      = 8'h24;
    localparam logic [7:0] PANEL_COLON_ON   = 8'h03;
    localparam logic [7:0] PANEL_BRIGHT     = 8'h30;
    localparam logic [7:0] PANEL_BRIGHT_LOW = 8'h1D;
    localparam logic [7:0] PANEL_DISP_ON    = 8'h2D;

    // edge cases around rounding, day wrap and the full input range
    localparam logic [31:0] DIRECTED_TS [20] = '{
        32'd0, 32'hFFFF_FFFF, 32'd30, 32'd31, 32'd59, 32'd60,
        32'd3599, 32'd3570, 32'd3571, 32'd86399, 32'd86370, 32'd86371,
        32'd86400, 32'd45296, 32'd35991, 32'd71985, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd4294943999
    };

    // one command beat as seen on the output channel
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              frame_start;
        logic              frame_end;
        logic              last;
    } t_panel_beat;

    // expected beats per timestamp, compared in order against the output
    class panel_scoreboard;
        t_panel_beat pending[$];
        int unsigned mismatches;

        function logic [7:0] seg_pattern(input int unsigned d);
            case (d)
                0: return 8'h3F;
                1: return 8'h06;
                2: return 8'h5B;
                3: return 8'h4F;
                4: return 8'h66;
                5: return 8'h6D;
                6: return 8'h7D;
                7: return 8'h07;
                8: return 8'h7F;
                default: return 8'h6F;
            endcase
        endfunction

        function void add_beat(input logic [7:0] b, input logic fs, input logic fe,
                               input logic lst);
            t_panel_beat beat;
            beat.data        = b;
            beat.frame_start = fs;
            beat.frame_end   = fe;
            beat.last        = lst;
            pending.push_back(beat);
        endfunction

        // accepted timestamp: reduce to rounded hh:mm and queue its ten beats
        function void note_timestamp(input logic [TS_W-1:0] ts);
            int unsigned t;
            int unsigned hh;
            int unsigned mm;
            int unsigned ss;
            t  = ts % 32'd86400;
            hh = t / 3600;
            t  = t % 3600;
            mm = t / 60;
            ss = t % 60;
            if (ss > 30) mm++;
            if (mm >= 60) begin
                mm = mm - 60;
                hh++;
            end
            if (hh >= 24) hh = hh - 24;
            add_beat(PANEL_WRITE, 1'b1, 1'b0, 1'b0);
            add_beat(seg_pattern(hh / 10), 1'b0, 1'b0, 1'b0);
            add_beat(seg_pattern(hh % 10), 1'b0, 1'b0, 1'b0);
            add_beat(seg_pattern(mm / 10), 1'b0, 1'b0, 1'b0);
            add_beat(seg_pattern(mm % 10), 1'b0, 1'b1, 1'b0);
            add_beat(PANEL_COLON, 1'b1, 1'b0, 1'b0);
            add_beat(PANEL_COLON_ON, 1'b0, 1'b1, 1'b0);
            add_beat(PANEL_BRIGHT, 1'b1, 1'b0, 1'b0);
            add_beat(PANEL_BRIGHT_LOW, 1'b0, 1'b1, 1'b0);
            add_beat(PANEL_DISP_ON, 1'b1, 1'b1, 1'b1);
        endfunction

        // accepted output beat: compare against the oldest expectation
        function void check_beat(input t_panel_beat got);
            t_panel_beat want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: data=%02h fs=%0b fe=%0b last=%0b",
                             got.data, got.frame_start, got.frame_end, got.last);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("beat mismatch: expected data=%02h fs=%0b fe=%0b last=%0b,",
                             want.data, want.frame_start, want.frame_end, want.last,
                             " got data=%02h fs=%0b fe=%0b last=%0b",
                             got.data, got.frame_start, got.frame_end, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    clkled_ts_if  ts_if();
    clkled_cmd_if cmd_if();

    panel_scoreboard sb;
    int unsigned     beats_taken;
    int unsigned     idle_cycles;

    clock_time_to_led_panel_commands u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ts    (ts_if),
        .o_cmd   (cmd_if)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offer one timestamp after a random gap (none if no_gap) and wait for it to be taken
    task automatic send_timestamp(input logic [TS_W-1:0] ts, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            ts_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        ts_if.valid             = 1'b1;
        ts_if.timestamp_seconds = ts;
        do @(posedge clk); while (!ts_if.ready);
        sb.note_timestamp(ts);
        @(negedge clk);
    endtask

    // receiver: random stalls, no-stall stretches and one long hold-off
    initial begin
        int unsigned stall;
        cmd_if.ready = 1'b0;
        beats_taken  = 0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (beats_taken == HOLD_AT_BEAT) begin
                cmd_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = ((beats_taken % 100) < 25) ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                cmd_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            cmd_if.ready = 1'b1;
            do @(posedge clk); while (!cmd_if.valid);
            sb.check_beat({cmd_if.out_byte, cmd_if.frame_start, cmd_if.frame_end,
                           cmd_if.last});
            beats_taken++;
            @(negedge clk);
        end
    end

    // watchdog on cycles without any accepted timestamp or beat
    always @(posedge clk) begin
        if (!rst_n || (ts_if.valid && ts_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        logic [TS_W-1:0] ts;
        longint unsigned day_base;
        int unsigned     sec_pick;
        sb                      = new();
        idle_cycles             = 0;
        rst_n                   = 1'b0;
        ts_if.valid             = 1'b0;
        ts_if.timestamp_seconds = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed edge cases
        foreach (DIRECTED_TS[i])
            send_timestamp(DIRECTED_TS[i], (i % 2) == 0);

        // random: full range, near rounding boundaries, and within one day
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: ts = $urandom;
                5, 6, 7: begin
                    day_base = longint'($urandom_range(0, 49709)) * 86400;
                    case ($urandom_range(0, 4))
                        0: sec_pick = 29;
                        1: sec_pick = 30;
                        2: sec_pick = 31;
                        3: sec_pick = 59;
                        default: sec_pick = 0;
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        ts = TS_W'(day_base + longint'($urandom_range(0, 23)) * 3600
                                   + 59 * 60 + sec_pick);
                    else
                        ts = TS_W'(day_base + longint'($urandom_range(0, 23)) * 3600
                                   + longint'($urandom_range(0, 59)) * 60 + sec_pick);
                end
                default: ts = $urandom_range(0, 86399);
            endcase
            send_timestamp(ts, (i % 40) < 8);
        end
        ts_if.valid = 1'b0;

        // drain outstanding beats, then give late extras a chance to show
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/clkled_pkg.sv
rtl/clkled_ts_if.sv
rtl/clkled_cmd_if.sv
rtl/clkled_front.sv
rtl/clkled_queue.sv
rtl/clkled_back.sv
rtl/clock_time_to_led_panel_commands.sv
tb/clock_time_to_led_panel_commands_test.sv
